// File: src/mfdc_pkg.sv
// Package for the masked frame difference checker.
// Shared widths, register and verdict codes, and the types passed between modules.
// No dependencies.
package mfdc_pkg;

	localparam int MAX_ROWS_DEF   = 4096;
	localparam int MAX_PIXELS_DEF = 16777216;
	localparam int QUEUE_DEPTH    = 4;

	localparam int COLOR_W   = 8;
	localparam int ROW_W     = 12;
	localparam int SROW_W    = 13;
	localparam int ROW_CMP_W = 17;
	localparam int SUM_W     = 10;
	localparam int TOL_W     = 10;
	localparam int PCT_W     = 14;
	localparam int CNT_OUT_W = 25;
	localparam int VERDICT_W = 2;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [PCT_W-1:0] SCALE = 14'd10000;

	localparam logic [VERDICT_W-1:0] VERDICT_CLEAN     = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_DIFFERENT = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_COVERED   = 2'd2;

	localparam logic [1:0] REG_TOLERANCE  = 2'd0;
	localparam logic [1:0] REG_DIFF_LIMIT = 2'd1;
	localparam logic [1:0] REG_OPEN_FLOOR = 2'd2;

	localparam logic [TOL_W-1:0] TOLERANCE_RESET  = 10'd24;
	localparam logic [PCT_W-1:0] DIFF_LIMIT_RESET = 14'd50;
	localparam logic [PCT_W-1:0] OPEN_FLOOR_RESET = 14'd200;

	typedef struct packed {
		logic [TOL_W-1:0] tolerance;
		logic [PCT_W-1:0] diff_limit;
		logic [PCT_W-1:0] open_floor;
	} cfg_t;

	// one classified pixel, as it travels from front to back
	typedef struct packed {
		logic             judged;
		logic             bad;
		logic [ROW_W-1:0] row;
		logic             last;
	} pix_cls_t;

endpackage

// File: src/mfdc_front.sv
// Front end of the checker: classifies one pixel pair as judged and/or bad.
// Clamps the row to the configured row range. Uses mfdc_pkg.
module mfdc_front import mfdc_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic [COLOR_W-1:0] cur_red,
	input  logic [COLOR_W-1:0] cur_green,
	input  logic [COLOR_W-1:0] cur_blue,
	input  logic [COLOR_W-1:0] ref_red,
	input  logic [COLOR_W-1:0] ref_green,
	input  logic [COLOR_W-1:0] ref_blue,
	input  logic               masked,
	input  logic [ROW_W-1:0]   row,
	input  logic               last_pixel,
	input  logic [TOL_W-1:0]   tolerance,
	output pix_cls_t           cls
);

	localparam logic [ROW_CMP_W-1:0] ROW_LIMIT = ROW_CMP_W'(MAX_ROWS);
	localparam logic [ROW_W-1:0]     ROW_TOP   = ROW_W'(MAX_ROWS - 1);

	function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	logic [SUM_W-1:0] diff_sum;

	assign diff_sum = SUM_W'(abs_diff(cur_red, ref_red))
		+ SUM_W'(abs_diff(cur_green, ref_green))
		+ SUM_W'(abs_diff(cur_blue, ref_blue));

	always_comb begin
		cls.judged = ~masked;
		cls.bad    = ~masked & (diff_sum > tolerance);
		cls.last   = last_pixel;
		if (ROW_CMP_W'(row) >= ROW_LIMIT) begin
			cls.row = ROW_TOP;
		end else begin
			cls.row = row;
		end
	end

endmodule

// File: src/mfdc_queue.sv
// Short FIFO of classified pixels between front and back.
// Register storage, one push and one pop port. Uses mfdc_pkg.
module mfdc_queue import mfdc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pix_cls_t push_data,
	output logic     full,
	input  logic     pop,
	output pix_cls_t head,
	output logic     nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pix_cls_t          slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign nonempty = (fill_q != '0);
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/mfdc_back.sv
// Back end: frame accumulators, then a two-stage verdict pipe and the output register.
// Multiplies in one stage, compares in the next. Uses mfdc_pkg.
module mfdc_back import mfdc_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     q_nonempty,
	input  pix_cls_t                 q_head,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [VERDICT_W-1:0]     verdict,
	output logic [CNT_OUT_W-1:0]     bad_count,
	output logic [CNT_OUT_W-1:0]     seen_count,
	output logic [CNT_OUT_W-1:0]     total_count,
	output logic signed [SROW_W-1:0] first_bad_row,
	output logic signed [SROW_W-1:0] last_bad_row
);

	localparam int             CW      = $clog2(MAX_PIXELS + 1);
	localparam int             PW      = CW + PCT_W;
	localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_PIXELS);

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
	endfunction

	// running frame totals
	logic [CW-1:0]    bad_q, seen_q, pix_q;
	logic             row_vld_q;
	logic [ROW_W-1:0] first_row_q, last_row_q;

	logic [CW-1:0]    bad_n, seen_n, pix_n;
	logic             hit, row_vld_n;
	logic [ROW_W-1:0] first_row_n, last_row_n;

	// stage 1: frame snapshot
	logic             v_s1;
	logic [CW-1:0]    bad_s1, seen_s1, pix_s1;
	logic             row_vld_s1;
	logic [ROW_W-1:0] first_row_s1, last_row_s1;

	// stage 2: products
	logic             v_s2;
	logic [CW-1:0]    bad_s2, seen_s2, pix_s2;
	logic             row_vld_s2;
	logic [ROW_W-1:0] first_row_s2, last_row_s2;
	logic [PW-1:0]    seen_x_s2, open_x_s2, bad_x_s2, lim_x_s2;

	logic out_valid_q;
	logic out_free, f2_free, f1_free;
	logic covered, too_diff;

	assign out_free = !out_valid_q || out_ready;
	assign f2_free  = !v_s2 || out_free;
	assign f1_free  = !v_s1 || f2_free;
	assign q_pop    = q_nonempty && (!q_head.last || f1_free);

	always_comb begin
		hit         = q_head.judged && q_head.bad;
		pix_n       = sat_inc(pix_q);
		seen_n      = q_head.judged ? sat_inc(seen_q) : seen_q;
		bad_n       = hit ? sat_inc(bad_q) : bad_q;
		row_vld_n   = row_vld_q || hit;
		first_row_n = (hit && !row_vld_q) ? q_head.row : first_row_q;
		last_row_n  = hit ? q_head.row : last_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q       <= '0;
			seen_q      <= '0;
			pix_q       <= '0;
			row_vld_q   <= 1'b0;
			first_row_q <= '0;
			last_row_q  <= '0;
		end else if (q_pop) begin
			if (q_head.last) begin
				bad_q     <= '0;
				seen_q    <= '0;
				pix_q     <= '0;
				row_vld_q <= 1'b0;
			end else begin
				bad_q       <= bad_n;
				seen_q      <= seen_n;
				pix_q       <= pix_n;
				row_vld_q   <= row_vld_n;
				first_row_q <= first_row_n;
				last_row_q  <= last_row_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (f1_free) begin
				v_s1 <= q_pop && q_head.last;
			end
			if (f2_free) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.last) begin
			bad_s1       <= bad_n;
			seen_s1      <= seen_n;
			pix_s1       <= pix_n;
			row_vld_s1   <= row_vld_n;
			first_row_s1 <= first_row_n;
			last_row_s1  <= last_row_n;
		end
		if (v_s1 && f2_free) begin
			bad_s2       <= bad_s1;
			seen_s2      <= seen_s1;
			pix_s2       <= pix_s1;
			row_vld_s2   <= row_vld_s1;
			first_row_s2 <= first_row_s1;
			last_row_s2  <= last_row_s1;
			seen_x_s2    <= PW'(seen_s1) * PW'(SCALE);
			open_x_s2    <= PW'(cfg.open_floor) * PW'(pix_s1);
			bad_x_s2     <= PW'(bad_s1) * PW'(SCALE);
			lim_x_s2     <= PW'(cfg.diff_limit) * PW'(seen_s1);
		end
	end

	assign covered  = (seen_s2 == '0) || (seen_x_s2 < open_x_s2);
	assign too_diff = bad_x_s2 > lim_x_s2;

	always_ff @(posedge clk) begin
		if (v_s2 && out_free) begin
			if (covered) begin
				verdict <= VERDICT_COVERED;
			end else if (too_diff) begin
				verdict <= VERDICT_DIFFERENT;
			end else begin
				verdict <= VERDICT_CLEAN;
			end
			bad_count     <= CNT_OUT_W'(bad_s2);
			seen_count    <= CNT_OUT_W'(seen_s2);
			total_count   <= CNT_OUT_W'(pix_s2);
			first_bad_row <= row_vld_s2 ? signed'({1'b0, first_row_s2}) : '1;
			last_bad_row  <= row_vld_s2 ? signed'({1'b0, last_row_s2}) : '1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/masked_frame_difference_checker.sv
// Masked frame difference checker, top level.
// Pixel pairs enter on the in_valid/in_ready channel in raster order, one per
// cycle while in_ready is high; each carries current and reference RGB, a mask
// bit, its row and a last_pixel flag. Unmasked pixels are judged; a judged
// pixel whose summed channel differences exceed the tolerance counts as bad.
// On the pixel flagged last_pixel, one result leaves on out_valid/out_ready:
// verdict (clean, too different, covered), the bad/seen/total counts and the
// first and last bad rows (-1 when none). Counters then restart for the next frame.
// Throughput: one pixel per cycle unless stalled, frames back to back with no gap.
// Path: after the last pixel's transfer the result is registered in turn in the
// queue, snapshot and multiply stage, then compared into the output register.
// Stalls: while out_ready is low the result holds; pixels keep accumulating
// into the next frame until a last pixel meets a full verdict pipe at the queue
// head; the 4-entry front queue then fills, at which point in_ready drops.
// Reset: counters clear, registers take tolerance 24, diff limit 50 and
// open floor 200 (hundredths of a percent). Config is written over the APB port.
module masked_frame_difference_checker import mfdc_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_PIXELS  = MAX_PIXELS_DEF,
	parameter int QUEUE_SLOTS = QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [COLOR_W-1:0]       cur_red,
	input  logic [COLOR_W-1:0]       cur_green,
	input  logic [COLOR_W-1:0]       cur_blue,
	input  logic [COLOR_W-1:0]       ref_red,
	input  logic [COLOR_W-1:0]       ref_green,
	input  logic [COLOR_W-1:0]       ref_blue,
	input  logic                     masked,
	input  logic [ROW_W-1:0]         row,
	input  logic                     last_pixel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [VERDICT_W-1:0]     verdict,
	output logic [CNT_OUT_W-1:0]     bad_count,
	output logic [CNT_OUT_W-1:0]     seen_count,
	output logic [CNT_OUT_W-1:0]     total_count,
	output logic signed [SROW_W-1:0] first_bad_row,
	output logic signed [SROW_W-1:0] last_bad_row
);

	cfg_t     cfg_q;
	pix_cls_t cls;
	pix_cls_t q_head;
	logic     q_full, q_nonempty, q_pop, push;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance  <= TOLERANCE_RESET;
			cfg_q.diff_limit <= DIFF_LIMIT_RESET;
			cfg_q.open_floor <= OPEN_FLOOR_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_TOLERANCE:  cfg_q.tolerance  <= pwdata[TOL_W-1:0];
				REG_DIFF_LIMIT: cfg_q.diff_limit <= pwdata[PCT_W-1:0];
				REG_OPEN_FLOOR: cfg_q.open_floor <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TOLERANCE:  prdata = PDATA_W'(cfg_q.tolerance);
			REG_DIFF_LIMIT: prdata = PDATA_W'(cfg_q.diff_limit);
			REG_OPEN_FLOOR: prdata = PDATA_W'(cfg_q.open_floor);
			default:        prdata = '0;
		endcase
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	mfdc_front #(.MAX_ROWS(MAX_ROWS)) u_front (
		.cur_red    (cur_red),
		.cur_green  (cur_green),
		.cur_blue   (cur_blue),
		.ref_red    (ref_red),
		.ref_green  (ref_green),
		.ref_blue   (ref_blue),
		.masked     (masked),
		.row        (row),
		.last_pixel (last_pixel),
		.tolerance  (cfg_q.tolerance),
		.cls        (cls)
	);

	mfdc_queue #(.DEPTH(QUEUE_SLOTS)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.nonempty  (q_nonempty)
	);

	mfdc_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_nonempty    (q_nonempty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.verdict       (verdict),
		.bad_count     (bad_count),
		.seen_count    (seen_count),
		.total_count   (total_count),
		.first_bad_row (first_bad_row),
		.last_bad_row  (last_bad_row)
	);

endmodule

// File: src/mfdc_checker.sv
// Port-level checks for the masked frame difference checker, bound to its top level.
// Sees only the top level's ports. Uses mfdc_pkg.
module mfdc_checker import mfdc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [VERDICT_W-1:0]     verdict,
	input logic [CNT_OUT_W-1:0]     bad_count,
	input logic [CNT_OUT_W-1:0]     seen_count,
	input logic [CNT_OUT_W-1:0]     total_count,
	input logic signed [SROW_W-1:0] first_bad_row,
	input logic signed [SROW_W-1:0] last_bad_row
);

	localparam logic [SROW_W-1:0] NO_ROW = '1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict)
			&& $stable(bad_count) && $stable(total_count))
		else $error("result changed while stalled");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bad_count <= seen_count) && (seen_count <= total_count))
		else $error("counts out of order");

	a_no_bad_rows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (first_bad_row == NO_ROW) |->
			(bad_count == '0) && (last_bad_row == NO_ROW))
		else $error("bad pixels without a bad row");

	a_nothing_judged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (seen_count == '0) |-> verdict == VERDICT_COVERED)
		else $error("empty frame not reported as covered");

	a_diff_needs_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == VERDICT_DIFFERENT) |-> bad_count != '0)
		else $error("too different with no bad pixel");

endmodule

bind masked_frame_difference_checker mfdc_checker u_mfdc_checker (.*);
